/* rtl/core/arwc_pkg.sv */
// ----------------------------------------------------------------------------
// arwc_pkg: anti-replay window check shared types and constants
// Packet word, verdict word, configuration struct and register indexes.
// ----------------------------------------------------------------------------
package arwc_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_REGEN_INTERVAL  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNDERFLOW_LIMIT = 1'd1;

  // register values after reset
  localparam logic [15:0] REGEN_INTERVAL_RESET  = 16'd3000;
  localparam logic [3:0]  UNDERFLOW_LIMIT_RESET = 4'd8;

  // underflow count saturates here
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // one received packet
  typedef struct packed {
    logic [31:0] current_challenge;
    logic [31:0] packet_nonce;
    logic [31:0] packet_counter;
    logic [31:0] now_ms;
  } pkt_t;

  // one verdict
  typedef struct packed {
    logic accepted;
    logic regen_request;
  } verdict_t;

  // live configuration
  typedef struct packed {
    logic [15:0] regen_interval_ms;
    logic [3:0]  underflow_limit;
  } cfg_t;

endpackage

/* rtl/core/arwc_stream_if.sv */
// ----------------------------------------------------------------------------
// arwc_stream_if: valid/ready stream channel
// Carries one word of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface arwc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/arwc_in_stage.sv */
// ----------------------------------------------------------------------------
// arwc_in_stage: input register
// Holds one packet word until the check stage takes it.
// ----------------------------------------------------------------------------
module arwc_in_stage
  import arwc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pkt_t in_data,
  input  logic advance,
  output logic held_valid,
  output pkt_t held_data
);

  // room when empty or when the held word moves on this cycle
  assign in_ready = !held_valid || advance;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

/* rtl/core/arwc_window.sv */
// ----------------------------------------------------------------------------
// arwc_window: sliding window state, replay check and result register
// Rebuilds the window on a challenge change, slides or marks the bitmap,
// counts too-old packets and raises renewal requests.
// ----------------------------------------------------------------------------
module arwc_window
  import arwc_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  pkt_t     item,
  input  cfg_t     cfg,
  input  logic     out_ready,
  output logic     res_valid,
  output verdict_t res_data
);

  localparam int unsigned IDX_W = $clog2(WINDOW_BITS);
  localparam logic [WINDOW_BITS-1:0] BIT0 = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
  localparam logic [31:0] WIN_SPAN = 32'(WINDOW_BITS);

  // stored state
  logic [31:0]            window_challenge;
  logic [31:0]            window_top;
  logic [WINDOW_BITS-1:0] seen_bitmap;
  logic [3:0]             underflow_count;
  logic [31:0]            last_regen_time;

  logic [31:0]            window_top_next;
  logic [WINDOW_BITS-1:0] seen_bitmap_next;
  logic [3:0]             underflow_count_next;
  logic [31:0]            last_regen_time_next;
  verdict_t               verdict;

  // check and next state
  always_comb begin
    logic                   chg;
    logic [31:0]            top_e;
    logic [WINDOW_BITS-1:0] bm_e;
    logic [WINDOW_BITS-1:0] bm_slid;
    logic [3:0]             cnt_e;
    logic [3:0]             cnt_inc;
    logic [31:0]            slide;
    logic [31:0]            lag;
    logic [31:0]            elapsed;
    logic                   bad;
    logic                   above;
    logic                   slide_in;
    logic                   lag_in;
    logic                   seen_bit;
    logic                   due;
    logic                   limit_hit;

    // a new challenge starts an empty window
    chg   = item.current_challenge != window_challenge;
    top_e = chg ? '0 : window_top;
    bm_e  = chg ? '0 : seen_bitmap;
    cnt_e = chg ? '0 : underflow_count;

    bad      = (item.packet_nonce != item.current_challenge) || (item.packet_counter == '0);
    above    = item.packet_counter > top_e;
    slide    = item.packet_counter - top_e;
    lag      = top_e - item.packet_counter;
    slide_in = slide < WIN_SPAN;
    lag_in   = lag < WIN_SPAN;
    bm_slid  = slide_in ? (bm_e << slide[IDX_W-1:0]) : '0;
    seen_bit = lag_in ? bm_e[lag[IDX_W-1:0]] : 1'b0;

    // renewal timing, wrap-safe
    elapsed   = item.now_ms - last_regen_time;
    due       = elapsed > {16'd0, cfg.regen_interval_ms};
    cnt_inc   = (cnt_e < COUNT_MAX) ? cnt_e + 4'd1 : cnt_e;
    limit_hit = cnt_inc >= cfg.underflow_limit;

    window_top_next       = top_e;
    seen_bitmap_next      = bm_e;
    underflow_count_next  = cnt_e;
    last_regen_time_next  = last_regen_time;
    verdict.accepted      = 1'b0;
    verdict.regen_request = 1'b0;

    priority if (bad) begin
      // wrong nonce or zero counter: reject; window only reset on a new challenge
    end else if (above) begin
      seen_bitmap_next     = bm_slid | BIT0;
      window_top_next      = item.packet_counter;
      underflow_count_next = '0;
      verdict.accepted     = 1'b1;
    end else if (lag_in) begin
      if (!seen_bit) begin
        seen_bitmap_next = bm_e | (BIT0 << lag[IDX_W-1:0]);
        verdict.accepted = 1'b1;
      end
    end else begin
      // too old
      underflow_count_next = limit_hit ? '0 : cnt_inc;
      if (limit_hit && due) begin
        last_regen_time_next  = item.now_ms;
        verdict.regen_request = 1'b1;
      end
    end
  end

  // state update and result occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      window_challenge <= '0;
      window_top       <= '0;
      seen_bitmap      <= '0;
      underflow_count  <= '0;
      last_regen_time  <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (fire) begin
        window_challenge <= item.current_challenge;
        window_top       <= window_top_next;
        seen_bitmap      <= seen_bitmap_next;
        underflow_count  <= underflow_count_next;
        last_regen_time  <= last_regen_time_next;
        res_valid        <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= verdict;
    end
  end

endmodule

/* rtl/core/anti_replay_window_check.sv */
// ----------------------------------------------------------------------------
// anti_replay_window_check: sliding-window replay filter
// Accepts each packet counter once within a window under the challenge in
// force and asks for a new challenge after repeated too-old packets.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  pkt      in   pkt.valid/pkt.ready  current_challenge, packet_nonce,
//                                     packet_counter, now_ms
//  res      out  res.valid/res.ready  accepted, regen_request
//  cfg      in   cfg_we               cfg_index, cfg_data
//
//  one packet per cycle unless the result stalls; the input register holds
//  a taken packet while the check runs, and the result register captures
//  its verdict together with the window state update and raises res.valid.
//  rst clears the window state, both registers and restores the config.
//  a stalled result holds; the input register still takes one more packet.
// ----------------------------------------------------------------------------
module anti_replay_window_check
  import arwc_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  arwc_stream_if.sink            pkt,
  arwc_stream_if.source          res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  logic     advance;
  logic     held_valid;
  pkt_t     held_data;
  logic     res_valid;
  verdict_t res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.regen_interval_ms <= REGEN_INTERVAL_RESET;
      cfg.underflow_limit   <= UNDERFLOW_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGEN_INTERVAL:  cfg.regen_interval_ms <= cfg_data;
        CFG_UNDERFLOW_LIMIT: cfg.underflow_limit   <= cfg_data[3:0];
      endcase
    end
  end

  // result register free or emptying
  assign advance = !res_valid || res.ready;

  arwc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pkt.valid),
    .in_ready   (pkt.ready),
    .in_data    (pkt.data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  arwc_window #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .fire      (held_valid && advance),
    .item      (held_data),
    .cfg       (cfg),
    .out_ready (res.ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

/* rtl/core/arwc_checker.sv */
// ----------------------------------------------------------------------------
// arwc_checker: port-level checks for the replay filter
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module arwc_checker (
  input logic clk,
  input logic rst,
  input logic pkt_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_accepted,
  input logic res_regen
);

  // a renewal request only comes with a rejected packet
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_regen |-> !res_accepted)
    else $error("regen request on an accepted packet");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // with no result waiting the input side is always open
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pkt_ready)
    else $error("input stalled with empty result register");

  // a stalled verdict holds its word
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_accepted) && $stable(res_regen))
    else $error("stalled verdict changed");

endmodule

bind anti_replay_window_check arwc_checker u_arwc_checker (
  .clk          (clk),
  .rst          (rst),
  .pkt_ready    (pkt.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_accepted (res.data.accepted),
  .res_regen    (res.data.regen_request)
);

/* test/tb_anti_replay_window_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anti_replay_window_check: replay filter regression
// Drives packet words through the window check and compares every verdict
// against a pinned verdict or an in-bench predictor of the sliding window,
// underflow count and renewal timer. A directed list covers the edge cases,
// then random traffic runs under six register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_anti_replay_window_check;
  import arwc_pkg::*;

  localparam int unsigned WINDOW_BITS   = 64;
  localparam logic [63:0] WIN_MASK      = (WINDOW_BITS >= 64) ? '1 :
                                          ((64'd1 << WINDOW_BITS) - 64'd1);
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [31:0] CHAL_A        = 32'hA5A5_0001;

  typedef enum logic {ROW_WORD, ROW_REGS} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    pkt_t        word;
    bit          pinned;
    verdict_t    verdict;
    logic [15:0] interval;
    logic [3:0]  limit;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  arwc_stream_if #(.payload_t(pkt_t))     pkt_ch ();
  arwc_stream_if #(.payload_t(verdict_t)) res_ch ();

  anti_replay_window_check #(
    .WINDOW_BITS(WINDOW_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted window state and live registers
  logic [31:0] win_chal   = '0;
  logic [31:0] win_top    = '0;
  logic [63:0] seen_map   = '0;
  logic [3:0]  uf_count   = '0;
  logic [31:0] last_regen = '0;
  logic [15:0] ival_reg   = REGEN_INTERVAL_RESET;
  logic [3:0]  lim_reg    = UNDERFLOW_LIMIT_RESET;

  // host side view used to shape random traffic
  logic [31:0] host_chal  = '0;
  logic [31:0] host_clock = '0;

  verdict_t    verdicts_due[$];
  int unsigned mismatches  = 0;
  int unsigned verdict_idx = 0;
  int unsigned cycles      = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // verdict for one packet word, advancing the predicted window
  function automatic verdict_t judge_packet(pkt_t w);
    verdict_t    v;
    logic [31:0] slide;
    logic [31:0] lag;
    v = '0;
    if (w.current_challenge != win_chal) begin
      win_chal = w.current_challenge;
      win_top  = '0;
      seen_map = '0;
      uf_count = '0;
    end
    if (w.packet_nonce != w.current_challenge || w.packet_counter == '0) begin
      v.accepted = 1'b0;
    end else if (w.packet_counter > win_top) begin
      slide    = w.packet_counter - win_top;
      seen_map = (slide >= WINDOW_BITS) ? '0 : ((seen_map << slide[5:0]) & WIN_MASK);
      seen_map[0] = 1'b1;
      win_top  = w.packet_counter;
      uf_count = '0;
      v.accepted = 1'b1;
    end else begin
      lag = win_top - w.packet_counter;
      if (lag < WINDOW_BITS) begin
        if (!seen_map[lag[5:0]]) begin
          seen_map[lag[5:0]] = 1'b1;
          v.accepted = 1'b1;
        end
      end else begin
        // too old: count, and maybe ask for renewal
        if (uf_count < COUNT_MAX) uf_count = uf_count + 4'd1;
        if (uf_count >= lim_reg) begin
          if (w.now_ms - last_regen > {16'd0, ival_reg}) begin
            last_regen = w.now_ms;
            v.regen_request = 1'b1;
          end
          uf_count = '0;
        end
      end
    end
    return v;
  endfunction

  // random packet: mostly well formed, aimed around the window top
  function automatic pkt_t make_packet();
    pkt_t        w;
    int unsigned pick;
    logic [31:0] top_now;
    if ($urandom_range(99) < 5) host_chal = $urandom();
    if ($urandom_range(49) == 0) host_clock = $urandom();
    else host_clock = host_clock + $urandom_range(0, 900);
    top_now = (host_chal == win_chal) ? win_top : '0;
    w.current_challenge = host_chal;
    w.packet_nonce      = host_chal;
    w.now_ms            = host_clock;
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.packet_counter = top_now + $urandom_range(1, 40);
    end else if (pick < 55) begin
      w.packet_counter = top_now - $urandom_range(0, WINDOW_BITS - 1);
    end else if (pick < 82) begin
      w.packet_counter = top_now - $urandom_range(WINDOW_BITS, 3000);
    end else if (pick < 87) begin
      w.packet_counter = top_now + $urandom_range(WINDOW_BITS, 5000);
    end else if (pick < 92) begin
      w.packet_counter = $urandom();
    end else if (pick < 96) begin
      w.packet_counter = top_now + 1;
      w.packet_nonce   = $urandom();
    end else begin
      w.packet_counter = '0;
    end
    return w;
  endfunction

  function automatic stim_row_t word_row(logic [31:0] chal, logic [31:0] nonce,
                                         logic [31:0] ctr, logic [31:0] now,
                                         bit pinned, logic acc, logic req);
    stim_row_t r;
    r.kind     = ROW_WORD;
    r.word     = '{current_challenge: chal, packet_nonce: nonce,
                   packet_counter: ctr, now_ms: now};
    r.pinned   = pinned;
    r.verdict  = '{accepted: acc, regen_request: req};
    r.interval = '0;
    r.limit    = '0;
    return r;
  endfunction

  function automatic stim_row_t regs_row(logic [15:0] interval, logic [3:0] limit);
    stim_row_t r;
    r.kind     = ROW_REGS;
    r.word     = '0;
    r.pinned   = 1'b0;
    r.verdict  = '0;
    r.interval = interval;
    r.limit    = limit;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at verdict %0d: %s", verdict_idx, msg);
  endtask

  // offer one word and wait for it to be taken
  task automatic send_word(pkt_t w, bit pinned, verdict_t typed);
    verdict_t v;
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= w;
    do @(posedge clk); while (!pkt_ch.ready);
    v = judge_packet(w);
    if (pinned) v = typed;
    verdicts_due.push_back(v);
  endtask

  // sender gap, one coin per cycle
  task automatic idle_sender();
    while ($urandom_range(99) < tx_idle_pct) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop offering and wait for every verdict to come back
  task automatic drain_verdicts();
    pkt_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back, block idle
  task automatic write_regs(logic [15:0] interval, logic [3:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REGEN_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= CFG_UNDERFLOW_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we   <= 1'b0;
    ival_reg = interval;
    lim_reg  = limit;
  endtask

  // receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      res_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // verdict check against the oldest prediction
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("none due, got accepted=%0b regen_request=%0b",
                                res_ch.data.accepted, res_ch.data.regen_request));
      end else begin
        want = verdicts_due.pop_front();
        if (res_ch.data.accepted !== want.accepted)
          flag_mismatch($sformatf("accepted expected %0b got %0b",
                                  want.accepted, res_ch.data.accepted));
        if (res_ch.data.regen_request !== want.regen_request)
          flag_mismatch($sformatf("regen_request expected %0b got %0b",
                                  want.regen_request, res_ch.data.regen_request));
      end
      verdict_idx++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("anti_replay_window_check regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   rows[$];
    logic [15:0] ival;
    logic [3:0]  lim;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pkt_ch.valid = 1'b0;
    pkt_ch.data  = '0;

    // directed words: zero counter, nonce mismatch, duplicate, extremes
    rows.push_back(word_row(32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 0));
    rows.push_back(word_row(32'h0, 32'h1, 32'h5, 32'h0, 1, 0, 0));
    rows.push_back(word_row(32'h0, 32'h0, 32'h1, 32'h0, 1, 1, 0));
    rows.push_back(word_row(32'h0, 32'h0, 32'h1, 32'h0, 1, 0, 0));
    // challenge change onto all ones, window edges
    rows.push_back(word_row('1, '1, '1, '1, 1, 1, 0));
    rows.push_back(word_row('1, '1, 32'hFFFF_FFC0, '1, 1, 1, 0));
    rows.push_back(word_row('1, '1, 32'hFFFF_FFBF, '1, 1, 0, 0));
    // count above a lowered limit, interval zero, then time wrap
    rows.push_back(regs_row(16'd0, 4'd1));
    rows.push_back(word_row('1, '1, 32'h1, 32'h0, 1, 0, 0));
    rows.push_back(word_row('1, '1, 32'h1, 32'h1, 1, 0, 1));
    rows.push_back(word_row('1, '1, 32'h1, 32'h0, 1, 0, 1));
    // large jump empties the bitmap
    rows.push_back(regs_row(16'hFFFF, 4'd15));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd10, 32'd0, 1, 1, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd74, 32'd0, 0, 0, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd11, 32'd0, 0, 0, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd74, 32'd0, 0, 0, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd75, 32'd0, 0, 0, 0));
    repeat (3) rows.push_back(word_row(CHAL_A, CHAL_A, 32'd1, 32'd0, 0, 0, 0));
    rows.push_back(regs_row(16'hFFFF, 4'd2));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd1, 32'h0001_0000, 0, 0, 0));
    // zero limit and wrap of the renewal timer
    rows.push_back(regs_row(16'd16, 4'd0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd1, 32'hFFFF_FFF8, 0, 0, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd1, 32'd8, 0, 0, 0));
    rows.push_back(word_row(CHAL_A, CHAL_A, 32'd1, 32'd9, 0, 0, 0));
    rows.push_back(regs_row(REGEN_INTERVAL_RESET, UNDERFLOW_LIMIT_RESET));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed walk
    tx_idle_pct = 12;
    rx_idle_pct = 71;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS) begin
        drain_verdicts();
        write_regs(rows[i].interval, rows[i].limit);
      end else begin
        send_word(rows[i].word, rows[i].pinned, rows[i].verdict);
        idle_sender();
      end
    end
    host_chal  = win_chal;
    host_clock = last_regen;

    // random phases over idle patterns and register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          ival = 16'd3000;
          lim  = 4'd8;
        end
        1: begin
          ival = 16'd0;
          lim  = 4'd1;
        end
        2: begin
          ival = 16'hFFFF;
          lim  = 4'd15;
        end
        3: begin
          ival = 16'd200;
          lim  = 4'd3;
        end
        4: begin
          ival = 16'($urandom_range(0, 65535));
          lim  = 4'($urandom_range(1, 15));
        end
        default: begin
          ival = 16'd50;
          lim  = 4'd4;
        end
      endcase
      drain_verdicts();
      write_regs(ival, lim);

      // long receiver hold while words keep coming, then a full pause
      if (ph == 2) begin
        rx_hold = 60;
        repeat (24) send_word(make_packet(), 1'b0, '0);
        drain_verdicts();
      end

      repeat (100) begin
        send_word(make_packet(), 1'b0, '0);
        idle_sender();
      end
    end

    drain_verdicts();
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("anti_replay_window_check regression: pass");
    end else begin
      $display("anti_replay_window_check regression: fail");
    end
    $finish;
  end

endmodule
